FILE: rtl/gdc_pkg.sv
// Package for the grid ray caster: map geometry, distance limit, result codes,
// the queued item type and the map write bundle.
// No dependencies.
package gdc_pkg;

    localparam int MAP_DIM   = 8;
    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
    localparam int MAP_AW    = $clog2(MAP_CELLS);

    localparam int CELL_W = 12;
    localparam int STEP_W = 25;
    localparam int ACC_W  = 26;

    localparam logic [STEP_W-1:0] DIST_LIMIT = STEP_W'(1) << 24;

    localparam logic [1:0] KIND_Y    = 2'd0;
    localparam logic [1:0] KIND_X    = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [7:0] CELL_EDGE_RST = 8'd50;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         cell_row;
        logic [2:0]         cell_col;
        logic [3:0]         cell_value;
        logic [15:0]        start_x;
        logic [15:0]        start_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        logic [3:0]        data;
    } t_map_wr;

endpackage

FILE: rtl/gdc_queue.sv
// Front part of the grid ray caster: accepts items and holds them in a
// two-entry queue for the back part. Uses gdc_pkg.
module gdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gdc_pkg::t_item i_item,
    output logic          o_busy,
    output gdc_pkg::t_item o_head,
    output logic          o_head_valid,
    input  logic          i_pop
);

    gdc_pkg::t_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_busy       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rp];
    assign w_push       = i_start && !o_busy;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: rtl/gdc_divider.sv
// Shared restoring divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. No dependencies.
module gdc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_sh;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 16'd0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_sh - {1'b0, r_den}) : w_sh[15:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/gdc_map.sv
// Wall map memory with a valid bit per cell; unwritten cells read as empty.
// Registered read. Uses gdc_pkg.
module gdc_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gdc_pkg::t_map_wr          i_wr,
    input  logic [gdc_pkg::MAP_AW-1:0] i_rd_addr,
    output logic [3:0]                o_rd_data
);

    logic [3:0] r_mem [gdc_pkg::MAP_CELLS];
    logic [gdc_pkg::MAP_CELLS-1:0] r_vld;
    logic [3:0] r_rdata;
    logic       r_rvld;

    assign o_rd_data = r_rvld ? r_rdata : 4'd0;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_rd_addr];
        end
    end

endmodule

FILE: rtl/gdc_caster.sv
// Back part of the grid ray caster: applies map writes and runs the ray
// setup (square root, divisions) and the DDA stepping loop, and forms the result.
// Uses gdc_pkg; drives the shared divider and the map memory.
module gdc_caster (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [7:0]                 i_cell_edge,
    input  gdc_pkg::t_item             i_head,
    input  logic                       i_head_valid,
    output logic                       o_pop,
    output gdc_pkg::t_map_wr           o_map_wr,
    output logic [gdc_pkg::MAP_AW-1:0] o_rd_addr,
    input  logic [3:0]                 i_rd_data,
    output logic                       o_div_start,
    output logic [31:0]                o_div_num,
    output logic [15:0]                o_div_den,
    input  logic                       i_div_done,
    input  logic [31:0]                i_div_quo,
    output logic                       o_done,
    output logic [1:0]                 o_hit_kind,
    output logic [15:0]                o_hit_distance,
    output logic [15:0]                o_hit_x,
    output logic [15:0]                o_hit_y,
    output logic [3:0]                 o_surface
);

    localparam int CW = gdc_pkg::CELL_W;
    localparam int SW = gdc_pkg::STEP_W;
    localparam int AW = gdc_pkg::ACC_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SQSUM = 12'b000000000010,
        S_SQRT  = 12'b000000000100,
        S_DIVC  = 12'b000000001000,
        S_DIVF  = 12'b000000010000,
        S_DIVS  = 12'b000000100000,
        S_FIRST = 12'b000001000000,
        S_STEP  = 12'b000010000000,
        S_CHECK = 12'b000100000000,
        S_HIT1  = 12'b001000000000,
        S_HIT2  = 12'b010000000000,
        S_HIT3  = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [15:0]          r_pos  [2];
    logic                 r_neg  [2];
    logic [15:0]          r_mag  [2];
    logic signed [CW-1:0] r_cell [2];
    logic [15:0]          r_f    [2];
    logic [SW-1:0]        r_step [2];
    logic [AW-1:0]        r_l    [2];
    logic [23:0]          r_pm   [2];
    logic [23:0]          r_m    [2];
    logic [7:0]           r_ce;
    logic [31:0]          r_sum;
    logic [15:0]          r_len;
    logic [3:0]           r_bit;
    logic                 r_axis;
    logic                 r_issued;
    logic [15:0]          r_rem;
    logic [23:0]          r_d;
    logic [1:0]           r_kind;
    logic [3:0]           r_surf;

    logic                 r_done;
    logic [1:0]           r_o_kind;
    logic [15:0]          r_o_dist;
    logic [15:0]          r_o_x;
    logic [15:0]          r_o_y;
    logic [3:0]           r_o_surf;

    logic [15:0]          w_t;
    logic [31:0]          w_tsq;
    logic [9:0]           w_c;
    logic [17:0]          w_cprod;
    logic [AW-1:0]        w_first [2];
    logic                 w_takex;
    logic [AW-1:0]        w_dsel;
    logic signed [CW-1:0] w_nc [2];
    logic                 w_inmap;
    logic [15:0]          w_h [2];
    logic [15:0]          w_pos;
    logic [15:0]          w_mag;

    assign w_pos = r_pos[r_axis];
    assign w_mag = r_mag[r_axis];

    assign o_pop = (r_state == S_IDLE) && i_head_valid;

    always_comb begin
        o_map_wr.en   = o_pop && (i_head.opcode == gdc_pkg::OP_WRITE)
                        && (32'(i_head.cell_row) < gdc_pkg::MAP_DIM)
                        && (32'(i_head.cell_col) < gdc_pkg::MAP_DIM);
        o_map_wr.addr = gdc_pkg::MAP_AW'(32'(i_head.cell_row) * gdc_pkg::MAP_DIM
                        + 32'(i_head.cell_col));
        o_map_wr.data = i_head.cell_value;
    end

    always_comb begin
        o_div_start = !r_issued && ((r_state == S_DIVC) || (r_state == S_DIVF)
                      || ((r_state == S_DIVS) && (w_mag != 16'd0)));
        priority if (r_state == S_DIVC) begin
            o_div_num = {22'd0, w_pos[15:6]};
            o_div_den = {8'd0, r_ce};
        end else if (r_state == S_DIVF) begin
            o_div_num = {r_rem, 16'd0};
            o_div_den = {2'd0, r_ce, 6'd0};
        end else begin
            o_div_num = {r_len, 16'd0};
            o_div_den = w_mag;
        end
    end

    assign w_t     = r_len | (16'd1 << r_bit);
    assign w_tsq   = 32'(w_t) * 32'(w_t);
    assign w_c     = i_div_quo[9:0];
    assign w_cprod = 18'(w_c) * 18'(r_ce);

    always_comb begin
        logic [16:0] g;
        logic [41:0] p;
        logic [25:0] l;
        for (int a = 0; a < 2; a++) begin
            g = r_neg[a] ? {1'b0, r_f[a]} : (17'h10000 - {1'b0, r_f[a]});
            p = 42'(g) * 42'(r_step[a]);
            l = p[41:16];
            w_first[a] = (l > AW'(gdc_pkg::DIST_LIMIT)) ? AW'(gdc_pkg::DIST_LIMIT) : l;
        end
    end

    assign w_takex = r_l[0] < r_l[1];
    assign w_dsel  = w_takex ? r_l[0] : r_l[1];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if ((a == 0) == w_takex) begin
                w_nc[a] = r_neg[a] ? r_cell[a] - CW'(1) : r_cell[a] + CW'(1);
            end else begin
                w_nc[a] = r_cell[a];
            end
        end
    end

    assign w_inmap = !w_nc[0][CW-1] && (32'(w_nc[0]) < gdc_pkg::MAP_DIM)
                     && !w_nc[1][CW-1] && (32'(w_nc[1]) < gdc_pkg::MAP_DIM);
    assign o_rd_addr = gdc_pkg::MAP_AW'(32'(w_nc[1][CW-2:0]) * gdc_pkg::MAP_DIM
                       + 32'(w_nc[0][CW-2:0]));

    always_comb begin
        logic signed [25:0] h;
        for (int a = 0; a < 2; a++) begin
            h = r_neg[a] ? $signed({10'd0, r_pos[a]}) - $signed({2'd0, r_m[a]})
                         : $signed({10'd0, r_pos[a]}) + $signed({2'd0, r_m[a]});
            if (h < 0) begin
                w_h[a] = 16'd0;
            end else if (h > 26'sd65535) begin
                w_h[a] = 16'hFFFF;
            end else begin
                w_h[a] = h[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [47:0] mp;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_pos[0] <= i_head.start_x;
                    r_pos[1] <= i_head.start_y;
                    r_neg[0] <= i_head.dir_x[15];
                    r_neg[1] <= i_head.dir_y[15];
                    r_mag[0] <= i_head.dir_x[15] ? 16'(-i_head.dir_x) : i_head.dir_x;
                    r_mag[1] <= i_head.dir_y[15] ? 16'(-i_head.dir_y) : i_head.dir_y;
                    r_ce     <= (i_cell_edge == 8'd0) ? 8'd1 : i_cell_edge;
                end
            end
            S_SQSUM: begin
                r_sum <= 32'(r_mag[0]) * 32'(r_mag[0]) + 32'(r_mag[1]) * 32'(r_mag[1]);
                r_len <= 16'd0;
                r_bit <= 4'd15;
            end
            S_SQRT: begin
                if (w_tsq <= r_sum) begin
                    r_len <= w_t;
                end
                r_bit <= r_bit - 4'd1;
            end
            S_DIVC: begin
                if (i_div_done) begin
                    r_cell[r_axis] <= CW'(w_c);
                    r_rem          <= w_pos - 16'({w_cprod, 6'd0});
                end
            end
            S_DIVF: begin
                if (i_div_done) begin
                    r_f[r_axis] <= i_div_quo[15:0];
                end
            end
            S_DIVS: begin
                if (w_mag == 16'd0) begin
                    r_step[r_axis] <= gdc_pkg::DIST_LIMIT;
                end else if (i_div_done) begin
                    r_step[r_axis] <= (i_div_quo > 32'(gdc_pkg::DIST_LIMIT))
                                      ? gdc_pkg::DIST_LIMIT : i_div_quo[SW-1:0];
                end
            end
            S_FIRST: begin
                r_l[0] <= w_first[0];
                r_l[1] <= w_first[1];
            end
            S_STEP: begin
                r_d <= w_dsel[23:0];
                r_cell[0] <= w_nc[0];
                r_cell[1] <= w_nc[1];
                if (w_takex) begin
                    r_l[0] <= r_l[0] + AW'(r_step[0]);
                    r_kind <= gdc_pkg::KIND_X;
                end else begin
                    r_l[1] <= r_l[1] + AW'(r_step[1]);
                    r_kind <= gdc_pkg::KIND_Y;
                end
            end
            S_CHECK: begin
                r_surf <= i_rd_data;
            end
            S_HIT1: begin
                r_pm[0] <= 24'(r_mag[0]) * 24'(r_ce);
                r_pm[1] <= 24'(r_mag[1]) * 24'(r_ce);
            end
            S_HIT2: begin
                for (int a = 0; a < 2; a++) begin
                    mp = 48'(r_pm[a]) * 48'(r_d);
                    r_m[a] <= mp[47:24];
                end
            end
            S_HIT3: begin
                r_o_kind <= r_kind;
                r_o_dist <= r_d[23:8];
                r_o_x    <= w_h[0];
                r_o_y    <= w_h[1];
                r_o_surf <= r_surf;
            end
            default: begin
            end
        endcase
        if ((r_state == S_STEP) && (w_dsel >= AW'(gdc_pkg::DIST_LIMIT))) begin
            r_o_kind <= gdc_pkg::KIND_NONE;
            r_o_dist <= 16'hFFFF;
            r_o_x    <= 16'd0;
            r_o_y    <= 16'd0;
            r_o_surf <= 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= 1'b0;
            r_issued <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (o_div_start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.opcode == gdc_pkg::OP_CAST)) begin
                        r_state <= S_SQSUM;
                    end
                end
                S_SQSUM: r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_bit == 4'd0) begin
                        r_axis  <= 1'b0;
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (i_div_done) begin
                        r_issued <= 1'b0;
                        r_state  <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    if (i_div_done) begin
                        r_issued <= 1'b0;
                        r_state  <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if ((w_mag == 16'd0) || i_div_done) begin
                        r_issued <= 1'b0;
                        if (r_axis) begin
                            r_state <= S_FIRST;
                        end else begin
                            r_axis  <= 1'b1;
                            r_state <= S_DIVC;
                        end
                    end
                end
                S_FIRST: r_state <= S_STEP;
                S_STEP: begin
                    if (w_dsel >= AW'(gdc_pkg::DIST_LIMIT)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_inmap) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: r_state <= (i_rd_data != 4'd0) ? S_HIT1 : S_STEP;
                S_HIT1:  r_state <= S_HIT2;
                S_HIT2:  r_state <= S_HIT3;
                S_HIT3: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_hit_kind     = r_o_kind;
    assign o_hit_distance = r_o_dist;
    assign o_hit_x        = r_o_x;
    assign o_hit_y        = r_o_y;
    assign o_surface      = r_o_surf;

endmodule

FILE: rtl/grid_ray_dda_cast.sv
// Top level of the grid ray caster: cell edge register, front queue, back
// caster, shared divider and wall map. Uses gdc_pkg and all gdc_* modules.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// Opcode write stores one 4-bit cell of the 8x8 map; it gives no result and
// is applied when the back part pops it from the queue. Opcode cast traces a ray and
// gives exactly one result: o_done is high for one cycle with the hit kind,
// distance, hit point and surface on the result ports.
// The front queue holds two items, so busy rises only when both wait.
// A cast runs the square root, then up to six divisions through the one shared
// divider, then the grid steps (a step that enters a cell in the map adds a map
// read), and for a hit forms the hit point in states S_HIT1, S_HIT2 and S_HIT3.
// Items are worked one at a time by the back part.
// The result has no back-pressure: the receiver must take it when o_done is
// high. i_cfg_we writes the cell edge; write it only while the block is idle.
// Reset clears the queue, the map (every cell reads zero) and sets the cell
// edge to 50.
module grid_ray_dda_cast (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [2:0]         i_cell_row,
    input  logic [2:0]         i_cell_col,
    input  logic [3:0]         i_cell_value,
    input  logic [15:0]        i_start_x,
    input  logic [15:0]        i_start_y,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_done,
    output logic [1:0]         o_hit_kind,
    output logic [15:0]        o_hit_distance,
    output logic [15:0]        o_hit_x,
    output logic [15:0]        o_hit_y,
    output logic [3:0]         o_surface
);

    logic [7:0]                 r_cell_edge;
    gdc_pkg::t_item             w_item;
    gdc_pkg::t_item             w_head;
    logic                       w_head_valid;
    logic                       w_pop;
    gdc_pkg::t_map_wr           w_map_wr;
    logic [gdc_pkg::MAP_AW-1:0] w_rd_addr;
    logic [3:0]                 w_rd_data;
    logic                       w_div_start;
    logic [31:0]                w_div_num;
    logic [15:0]                w_div_den;
    logic                       w_div_done;
    logic [31:0]                w_div_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_edge <= gdc_pkg::CELL_EDGE_RST;
        end else if (i_cfg_we) begin
            r_cell_edge <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_item.opcode     = i_opcode;
        w_item.cell_row   = i_cell_row;
        w_item.cell_col   = i_cell_col;
        w_item.cell_value = i_cell_value;
        w_item.start_x    = i_start_x;
        w_item.start_y    = i_start_y;
        w_item.dir_x      = i_dir_x;
        w_item.dir_y      = i_dir_y;
    end

    gdc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (w_item),
        .o_busy       (busy),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    gdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    gdc_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_map_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    gdc_caster u_caster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cell_edge    (r_cell_edge),
        .i_head         (w_head),
        .i_head_valid   (w_head_valid),
        .o_pop          (w_pop),
        .o_map_wr       (w_map_wr),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_div_start    (w_div_start),
        .o_div_num      (w_div_num),
        .o_div_den      (w_div_den),
        .i_div_done     (w_div_done),
        .i_div_quo      (w_div_quo),
        .o_done         (o_done),
        .o_hit_kind     (o_hit_kind),
        .o_hit_distance (o_hit_distance),
        .o_hit_x        (o_hit_x),
        .o_hit_y        (o_hit_y),
        .o_surface      (o_surface)
    );

endmodule
